FILE: rtl/core/dam_pkg.sv
// Shared types, codes and constants for the decimal accumulator machine.
// Used by dam_mem, dam_alu and decimal_accumulator_machine_core; no dependencies.

package dam_pkg;

    // Field widths
    localparam int WORD_W     = 15;
    localparam int VALUE_W    = 16;
    localparam int PC_W       = 7;
    localparam int STATUS_W   = 4;
    localparam int OPC_W      = 7;
    localparam int MAG_W      = 14;           // magnitude of a word, |w| <= 9999
    localparam int PROD_W     = 2 * WORD_W;   // wide add/sub/mul result
    localparam int OUT_DATA_W = 64;           // 57 payload bits, padded to bytes
    localparam int OUT_PAD_W  = 7;

    // Word range limits at the widths that need them
    localparam logic signed [VALUE_W-1:0] VAL_MAX  = 16'sd9999;
    localparam logic signed [VALUE_W-1:0] VAL_MIN  = -16'sd9999;
    localparam logic signed [PROD_W-1:0]  PROD_MAX = 30'sd9999;
    localparam logic signed [PROD_W-1:0]  PROD_MIN = -30'sd9999;

    // Opcode/address split: q = (w * 5243) >> 19 equals w / 100 for 0 <= w <= 9999
    localparam int              RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int              RECIP_SHIFT = 19;
    localparam logic [MAG_W-1:0] RADIX     = 14'd100;

    // Opcodes
    localparam logic [OPC_W-1:0] OPC_READ   = 7'd10;
    localparam logic [OPC_W-1:0] OPC_WRITE  = 7'd11;
    localparam logic [OPC_W-1:0] OPC_LOAD   = 7'd20;
    localparam logic [OPC_W-1:0] OPC_STORE  = 7'd21;
    localparam logic [OPC_W-1:0] OPC_ADD    = 7'd30;
    localparam logic [OPC_W-1:0] OPC_SUB    = 7'd31;
    localparam logic [OPC_W-1:0] OPC_DIV    = 7'd32;
    localparam logic [OPC_W-1:0] OPC_MUL    = 7'd33;
    localparam logic [OPC_W-1:0] OPC_BR     = 7'd40;
    localparam logic [OPC_W-1:0] OPC_BRNEG  = 7'd41;
    localparam logic [OPC_W-1:0] OPC_BRZERO = 7'd42;
    localparam logic [OPC_W-1:0] OPC_HALT   = 7'd43;

    typedef logic signed [WORD_W-1:0] word_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_LOADED       = 4'd0,
        STAT_EXECUTED     = 4'd1,
        STAT_WROTE        = 4'd2,
        STAT_HALTED       = 4'd3,
        STAT_OVERFLOW     = 4'd4,
        STAT_DIVZERO      = 4'd5,
        STAT_BAD_OPCODE   = 4'd6,
        STAT_BAD_VALUE    = 4'd7,
        STAT_LOAD_REFUSED = 4'd8,
        STAT_PC_END       = 4'd9,
        STAT_STOPPED      = 4'd10
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_DECODE,
        S_OPER,
        S_ALU,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } alu_kind_t;

    typedef struct packed {
        logic      start;
        alu_kind_t kind;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } alu_rsp_t;

    function automatic logic val_in_range(logic signed [VALUE_W-1:0] v);
        return (v >= VAL_MIN) && (v <= VAL_MAX);
    endfunction

endpackage

FILE: rtl/core/dam_mem.sv
// Main memory of the accumulator machine: one write port, one registered read port.
// Per-word valid bits make unwritten words read as zero right after reset. Uses dam_pkg.

module dam_mem #(
    parameter int WORDS = 100,
    localparam int AW   = $clog2(WORDS)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  dam_pkg::word_t wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output dam_pkg::word_t rdata
);
    import dam_pkg::*;

    word_t              mem_reg [WORDS];
    logic [WORDS-1:0]   valid_reg;
    word_t              rdata_reg;

    // Storage array and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= valid_reg[raddr] ? mem_reg[raddr] : '0;
        end
    end

    // Valid bits: cleared at reset, set on first write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/dam_alu.sv
// Shared arithmetic unit: add, subtract and multiply with a registered result, signed
// divide by a restoring loop of one quotient bit per cycle. Uses dam_pkg.

module dam_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  dam_pkg::alu_req_t req,
    input  dam_pkg::word_t    a,
    input  dam_pkg::word_t    b,
    output dam_pkg::alu_rsp_t rsp,
    output dam_pkg::word_t    result
);
    import dam_pkg::*;

    localparam int CNT_W = $clog2(MAG_W + 1);

    alu_kind_t                 kind_reg;
    logic signed [PROD_W-1:0]  wide_reg;
    logic [MAG_W-1:0]          rem_reg;
    logic [MAG_W-1:0]          quo_reg;
    logic [MAG_W-1:0]          dvs_reg;
    logic                      neg_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [WORD_W-1:0]         a_abs;
    logic [WORD_W-1:0]         b_abs;
    logic signed [PROD_W-1:0]  a_wide;
    logic signed [PROD_W-1:0]  b_wide;
    logic [MAG_W:0]            shifted;
    logic [MAG_W:0]            diff;
    logic                      take;
    word_t                     quo_word;

    // Operand magnitudes and sign extension
    assign a_abs  = a[WORD_W-1] ? WORD_W'(-a) : WORD_W'(a);
    assign b_abs  = b[WORD_W-1] ? WORD_W'(-b) : WORD_W'(b);
    assign a_wide = PROD_W'(a);
    assign b_wide = PROD_W'(b);

    // One restoring divide step
    assign shifted = {rem_reg, quo_reg[MAG_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign take    = (shifted >= {1'b0, dvs_reg});

    // Control: divide sequencing and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                if (req.kind == ALU_DIV)
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CNT_W'(MAG_W);
                end
                else
                begin
                    done_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            kind_reg <= req.kind;
            case (req.kind)
                ALU_ADD: wide_reg <= a_wide + b_wide;
                ALU_SUB: wide_reg <= a_wide - b_wide;
                ALU_MUL: wide_reg <= a_wide * b_wide;
                default:
                begin
                    quo_reg <= a_abs[MAG_W-1:0];
                    rem_reg <= '0;
                    dvs_reg <= b_abs[MAG_W-1:0];
                    neg_reg <= a[WORD_W-1] ^ b[WORD_W-1];
                end
            endcase
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
            quo_reg <= {quo_reg[MAG_W-2:0], take};
        end
    end

    // Result selection and range check
    assign quo_word = {1'b0, quo_reg};
    assign result   = (kind_reg == ALU_DIV) ? (neg_reg ? -quo_word : quo_word)
                                            : wide_reg[WORD_W-1:0];
    assign rsp.done = done_reg;
    assign rsp.ovf  = (kind_reg != ALU_DIV) && ((wide_reg > PROD_MAX) || (wide_reg < PROD_MIN));

endmodule

FILE: rtl/core/decimal_accumulator_machine_core.sv
// Decimal accumulator machine: sequencer, architectural registers and output register.
// Loads and steps that do not fetch go from accept straight to S_DONE; fetched steps pass
// S_FETCH and S_DECODE, most then S_OPER, and arithmetic adds S_ALU. S_DONE waits for a free output register.
// One item at a time; the divide loop in dam_alu (one bit per cycle) sets the longest case.
// Reset clears the control and architectural registers and the memory valid bits at once; no clearing pass.
// Depends on dam_pkg, dam_mem and dam_alu.

module decimal_accumulator_machine_core #(
    parameter int MEMORY_WORDS = 100
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] value
    input  logic [0:0]  s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [3:0] status, [18:4] out_value, [33:19] accumulator_now,
                                   // [40:34] pc_now, [55:41] instruction_now, [56] is_stopped
);
    import dam_pkg::*;

    localparam int              AW        = $clog2(MEMORY_WORDS);
    localparam logic [PC_W-1:0] MEM_LIMIT = PC_W'(MEMORY_WORDS);

    state_t                     state_reg, state_next;
    word_t                      acc_reg, acc_next;
    logic [PC_W-1:0]            pc_reg, pc_next;
    logic [PC_W-1:0]            lpos_reg, lpos_next;
    word_t                      ir_reg, ir_next;
    logic                       started_reg, started_next;
    logic                       stopped_reg, stopped_next;
    logic signed [VALUE_W-1:0]  val_reg, val_next;
    word_t                      word_reg, word_next;
    logic [OPC_W-1:0]           opc_reg, opc_next;
    status_t                    res_status_reg, res_status_next;
    word_t                      res_out_reg, res_out_next;
    word_t                      res_instr_reg, res_instr_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0]      m_tdata_reg, m_tdata_next;

    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    word_t                      mem_wdata;
    logic                       mem_re;
    logic [AW-1:0]              mem_raddr;
    word_t                      mem_rdata;

    alu_req_t                   alu_req;
    alu_rsp_t                   alu_rsp;
    word_t                      alu_result;

    logic [RECIP_W+MAG_W-1:0]   split_prod;
    logic [MAG_W-1:0]           opc_x100;
    logic [MAG_W-1:0]           addr_full;
    logic [PC_W-1:0]            addr;

    dam_mem #(
        .WORDS (MEMORY_WORDS)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    dam_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (acc_reg),
        .b      (mem_rdata),
        .rsp    (alu_rsp),
        .result (alu_result)
    );

    // Opcode by reciprocal multiply, address as the remainder
    assign split_prod = (RECIP_W + MAG_W)'(mem_rdata[MAG_W-1:0])
                      * (RECIP_W + MAG_W)'(RECIP_100);
    assign opc_x100   = MAG_W'(opc_reg) * RADIX;
    assign addr_full  = word_reg[MAG_W-1:0] - opc_x100;
    assign addr       = addr_full[PC_W-1:0];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        acc_next        = acc_reg;
        pc_next         = pc_reg;
        lpos_next       = lpos_reg;
        ir_next         = ir_reg;
        started_next    = started_reg;
        stopped_next    = stopped_reg;
        val_next        = val_reg;
        word_next       = word_reg;
        opc_next        = opc_reg;
        res_status_next = res_status_reg;
        res_out_next    = res_out_reg;
        res_instr_next  = res_instr_reg;
        m_tdata_next    = m_tdata_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = acc_reg;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        alu_req.start   = 1'b0;
        alu_req.kind    = ALU_ADD;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    val_next       = s_tdata;
                    res_out_next   = '0;
                    res_instr_next = ir_reg;
                    state_next     = S_DONE;
                    if (!s_tuser[0])
                    begin
                        // Program load
                        if (started_reg || (lpos_reg >= MEM_LIMIT))
                        begin
                            res_status_next = STAT_LOAD_REFUSED;
                        end
                        else if (!val_in_range(s_tdata))
                        begin
                            res_status_next = STAT_BAD_VALUE;
                        end
                        else
                        begin
                            mem_we          = 1'b1;
                            mem_waddr       = lpos_reg[AW-1:0];
                            mem_wdata       = s_tdata[WORD_W-1:0];
                            lpos_next       = lpos_reg + 1'b1;
                            res_status_next = STAT_LOADED;
                        end
                    end
                    else if (stopped_reg)
                    begin
                        res_status_next = STAT_STOPPED;
                    end
                    else
                    begin
                        started_next = 1'b1;
                        if (pc_reg >= MEM_LIMIT)
                        begin
                            stopped_next    = 1'b1;
                            res_status_next = STAT_PC_END;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = pc_reg[AW-1:0];
                            state_next = S_FETCH;
                        end
                    end
                end
            end

            S_FETCH:
            begin
                word_next  = mem_rdata;
                opc_next   = split_prod[RECIP_SHIFT+OPC_W-1:RECIP_SHIFT];
                state_next = S_DECODE;
            end

            S_DECODE:
            begin
                res_instr_next = word_reg;
                state_next     = S_DONE;
                if (!word_reg[WORD_W-1] && (opc_reg == OPC_READ) && !val_in_range(val_reg))
                begin
                    // Read value rejected; step can be retried
                    res_status_next = STAT_BAD_VALUE;
                end
                else
                begin
                    ir_next = word_reg;
                    pc_next = pc_reg + 1'b1;
                    if (word_reg[WORD_W-1] ||
                        !(opc_reg inside {OPC_READ, OPC_WRITE, OPC_LOAD, OPC_STORE,
                                          OPC_ADD, OPC_SUB, OPC_DIV, OPC_MUL,
                                          OPC_BR, OPC_BRNEG, OPC_BRZERO, OPC_HALT}))
                    begin
                        stopped_next    = 1'b1;
                        res_status_next = STAT_BAD_OPCODE;
                    end
                    else if (opc_reg == OPC_HALT)
                    begin
                        stopped_next    = 1'b1;
                        res_status_next = STAT_HALTED;
                    end
                    else if (addr >= MEM_LIMIT)
                    begin
                        stopped_next    = 1'b1;
                        res_status_next = STAT_BAD_OPCODE;
                    end
                    else
                    begin
                        mem_re          = 1'b1;
                        mem_raddr       = addr[AW-1:0];
                        res_status_next = STAT_EXECUTED;
                        state_next      = S_OPER;
                    end
                end
            end

            S_OPER:
            begin
                // Operand is on mem_rdata
                state_next = S_DONE;
                case (opc_reg)
                    OPC_READ:
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = addr[AW-1:0];
                        mem_wdata = val_reg[WORD_W-1:0];
                    end
                    OPC_WRITE:
                    begin
                        res_status_next = STAT_WROTE;
                        res_out_next    = mem_rdata;
                    end
                    OPC_LOAD:
                    begin
                        acc_next = mem_rdata;
                    end
                    OPC_STORE:
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = addr[AW-1:0];
                        mem_wdata = acc_reg;
                    end
                    OPC_ADD:
                    begin
                        alu_req.start = 1'b1;
                        alu_req.kind  = ALU_ADD;
                        state_next    = S_ALU;
                    end
                    OPC_SUB:
                    begin
                        alu_req.start = 1'b1;
                        alu_req.kind  = ALU_SUB;
                        state_next    = S_ALU;
                    end
                    OPC_MUL:
                    begin
                        alu_req.start = 1'b1;
                        alu_req.kind  = ALU_MUL;
                        state_next    = S_ALU;
                    end
                    OPC_DIV:
                    begin
                        if (mem_rdata == '0)
                        begin
                            stopped_next    = 1'b1;
                            res_status_next = STAT_DIVZERO;
                        end
                        else
                        begin
                            alu_req.start = 1'b1;
                            alu_req.kind  = ALU_DIV;
                            state_next    = S_ALU;
                        end
                    end
                    OPC_BR:
                    begin
                        pc_next = addr;
                    end
                    OPC_BRNEG:
                    begin
                        if (acc_reg[WORD_W-1])
                        begin
                            pc_next = addr;
                        end
                    end
                    OPC_BRZERO:
                    begin
                        if (acc_reg == '0)
                        begin
                            pc_next = addr;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_ALU:
            begin
                if (alu_rsp.done)
                begin
                    state_next = S_DONE;
                    if (alu_rsp.ovf)
                    begin
                        stopped_next    = 1'b1;
                        res_status_next = STAT_OVERFLOW;
                    end
                    else
                    begin
                        acc_next = alu_result;
                    end
                end
            end

            S_DONE:
            begin
                // Hand the result to the output register once it is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{OUT_PAD_W{1'b0}}, stopped_reg, res_instr_reg, pc_reg,
                                     acc_reg, res_out_reg, res_status_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            acc_reg      <= '0;
            pc_reg       <= '0;
            lpos_reg     <= '0;
            ir_reg       <= '0;
            started_reg  <= 1'b0;
            stopped_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            acc_reg      <= acc_next;
            pc_reg       <= pc_next;
            lpos_reg     <= lpos_next;
            ir_reg       <= ir_next;
            started_reg  <= started_next;
            stopped_reg  <= stopped_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        val_reg        <= val_next;
        word_reg       <= word_next;
        opc_reg        <= opc_next;
        res_status_reg <= res_status_next;
        res_out_reg    <= res_out_next;
        res_instr_reg  <= res_instr_next;
        m_tdata_reg    <= m_tdata_next;
    end

endmodule
